// File: hw/rtl/bnms_pkg.sv
// Types, constants and helpers shared by the box suppression block.
`default_nettype none
package bnms_pkg;

   localparam logic [15:0] THRESH_RESET = 16'd29491;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
   } box_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } nms_state_type;

   // Length of a span, zero when the upper edge does not exceed the lower one.
   function automatic logic [15:0] span_len(input logic signed [15:0] lo,
                                            input logic signed [15:0] hi);
      logic signed [16:0] diff;
      diff = 17'(hi) - 17'(lo);
      return (hi > lo) ? diff[15:0] : 16'd0;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/box_nonmax_suppression.sv
// Greedy IoU non-maximum suppression with the kept boxes held in one memory.
//
//   channel | ports          | content
//   --------+----------------+------------------------------------------------------
//   request | req_t*         | tdata: left, top, right, bottom; tuser: first_of_set
//   result  | rsp_t*         | tdata: keep, kept_slot, box_position, store_full
//   control | csr_wr_*       | iou_threshold, written when csr_wr_en is high
//
// A request is taken in the idle state. With a nonempty kept list and no new set, the
// memory is read one entry per cycle into a five-stage overlap pipeline and the result
// loads once that pipeline has drained; otherwise it loads without reading the memory.
// The next request is taken in the cycle after the load, so one request is in work at a
// time. A waiting result does not hold off the next request; only that request's own
// load waits for the result register to free up. Reset is synchronous and empties the kept
// list; memory contents are left as is.
`default_nettype none
module box_nonmax_suppression
   import bnms_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // box_left, box_top, box_right, box_bottom
   input  wire logic        req_tuser,   // first_of_set
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // keep, kept_slot, box_position, store_full
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_KEPT);
   localparam int CNT_W = $clog2(MAX_KEPT + 1);

   nms_state_type state_ff, state_in;

   logic [15:0]      thresh_ff;
   logic [CNT_W-1:0] count_ff;
   logic [15:0]      pos_ff;
   logic [15:0]      item_pos_ff;
   box_type          cur_ff;
   logic [15:0]      cw_ff, ch_ff;
   logic [31:0]      carea_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             supp_ff;

   box_type          kept_mem [MAX_KEPT];
   box_type          mem_rd_ff;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [15:0]      iw_ff, ih_ff, sw_ff, sh_ff;
   logic [31:0]      inter2_ff, sarea_ff;
   logic [31:0]      inter3_ff, inter4_ff;
   logic [33:0]      uni_ff;
   logic [49:0]      prod_ff;

   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;

   logic             accept, rd_en, load, last_rd, pipe_busy, room;
   logic             keep_now, full_now;
   box_type          req_box;
   logic signed [15:0] il, it, ir, ib;

   assign req_box.left   = req_tdata[15:0];
   assign req_box.top    = req_tdata[31:16];
   assign req_box.right  = req_tdata[47:32];
   assign req_box.bottom = req_tdata[63:48];

   assign accept    = req_tvalid && req_tready;
   assign last_rd   = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
   assign room      = !rsp_valid_ff || rsp_tready;
   assign keep_now  = !supp_ff && (count_ff < CNT_W'(MAX_KEPT));
   assign full_now  = !supp_ff && (count_ff >= CNT_W'(MAX_KEPT));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser || count_ff == '0) state_in = ST_DRAIN;
               else state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_rd) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  rd_en      = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  load       = room;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         count_ff     <= '0;
         pos_ff       <= '0;
         rd_idx_ff    <= '0;
         supp_ff      <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) thresh_ff <= csr_wr_data;
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (accept) begin
            rd_idx_ff <= '0;
            supp_ff   <= 1'b0;
            if (req_tuser) begin
               count_ff <= '0;
               pos_ff   <= 16'd1;
            end else if (pos_ff != 16'hFFFF) begin
               pos_ff <= pos_ff + 16'd1;
            end
         end
         if (rd_en) rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         if (v5_ff && ({2'b00, inter4_ff, 16'd0} > prod_ff)) supp_ff <= 1'b1;
         if (load && keep_now) count_ff <= count_ff + CNT_W'(1);
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff      <= req_box;
         cw_ff       <= span_len(req_box.left, req_box.right);
         ch_ff       <= span_len(req_box.top, req_box.bottom);
         item_pos_ff <= req_tuser ? 16'd0 : pos_ff;
      end
      carea_ff <= cw_ff * ch_ff;
      if (load) begin
         rsp_data_ff <= {full_now, item_pos_ff, (keep_now ? 6'(count_ff) : 6'd0), keep_now};
      end
   end

   always_ff @(posedge clock) begin
      if (load && keep_now) kept_mem[count_ff[IDX_W-1:0]] <= cur_ff;
      if (rd_en) mem_rd_ff <= kept_mem[rd_idx_ff];
   end

   assign il = (cur_ff.left > mem_rd_ff.left) ? cur_ff.left : mem_rd_ff.left;
   assign it = (cur_ff.top > mem_rd_ff.top) ? cur_ff.top : mem_rd_ff.top;
   assign ir = (cur_ff.right < mem_rd_ff.right) ? cur_ff.right : mem_rd_ff.right;
   assign ib = (cur_ff.bottom < mem_rd_ff.bottom) ? cur_ff.bottom : mem_rd_ff.bottom;

   always_ff @(posedge clock) begin
      iw_ff     <= span_len(il, ir);
      ih_ff     <= span_len(it, ib);
      sw_ff     <= span_len(mem_rd_ff.left, mem_rd_ff.right);
      sh_ff     <= span_len(mem_rd_ff.top, mem_rd_ff.bottom);
      inter2_ff <= iw_ff * ih_ff;
      sarea_ff  <= sw_ff * sh_ff;
      uni_ff    <= 34'(carea_ff) + 34'(sarea_ff) - 34'(inter2_ff);
      inter3_ff <= inter2_ff;
      prod_ff   <= 50'(thresh_ff) * 50'(uni_ff);
      inter4_ff <= inter3_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bnms_checker.sv
// Port-level checks for the box suppression block, bound to its top level.
`default_nettype none
module bnms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [63:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        csr_wr_en,
   input wire logic [15:0] csr_wr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result dropped while stalled.");

   a_keep_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[23]))
      else $error("Result both kept and flagged as store full.");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[6:1] == 6'd0)
      else $error("Dropped box reports a nonzero slot.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("New request taken while the previous one is in work.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind box_nonmax_suppression bnms_checker u_bnms_checker (.*);
`default_nettype wire

// File: verif/box_nms_checker.sv
// Checker that predicts each box decision and compares it with the result channel.
`default_nettype none
module box_nms_checker
   import bnms_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // box_left, box_top, box_right, box_bottom
   input  wire logic        req_tuser,   // first_of_set
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // keep, kept_slot, box_position, store_full
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   output int               mismatch_count,
   output int               decisions_owed
);

   typedef struct packed {
      logic        store_full;
      logic [15:0] position;
      logic [5:0]  slot;
      logic        keep;
   } decision_type;

   box_type      kept_list [MAX_KEPT];
   int           kept_total = 0;
   logic [15:0]  next_position = '0;
   logic [15:0]  iou_limit = THRESH_RESET;
   decision_type expected_decisions [$];
   int           mismatches = 0;
   int           owed = 0;

   assign mismatch_count = mismatches;
   assign decisions_owed = owed;

   function automatic longint extent_of(input logic signed [15:0] lo,
                                        input logic signed [15:0] hi);
      return (hi > lo) ? longint'(int'(hi) - int'(lo)) : 64'sd0;
   endfunction

   function automatic longint area_of(input box_type b);
      return extent_of(b.left, b.right) * extent_of(b.top, b.bottom);
   endfunction

   function automatic bit iou_above_limit(input box_type a, input box_type b,
                                          input logic [15:0] limit_value);
      logic signed [15:0] l, t, r, d;
      longint inter, uni;
      l = (a.left > b.left) ? a.left : b.left;
      t = (a.top > b.top) ? a.top : b.top;
      r = (a.right < b.right) ? a.right : b.right;
      d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
      inter = extent_of(l, r) * extent_of(t, d);
      uni = area_of(a) + area_of(b) - inter;
      return (inter <<< 16) > longint'(limit_value) * uni;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic predict_decision(input box_type cur, input logic first_box);
      decision_type want;
      bit survives;
      want = '0;
      survives = 1'b1;
      if (first_box) begin
         kept_total = 0;
         next_position = '0;
      end
      want.position = next_position;
      if (next_position != 16'hFFFF) begin
         next_position = next_position + 16'd1;
      end
      for (int i = 0; i < kept_total; i++) begin
         if (iou_above_limit(cur, kept_list[i], iou_limit)) begin
            survives = 1'b0;
         end
      end
      if (survives && kept_total < MAX_KEPT) begin
         kept_list[kept_total] = cur;
         want.keep = 1'b1;
         want.slot = 6'(kept_total);
         kept_total++;
      end else if (survives) begin
         want.store_full = 1'b1;
      end
      expected_decisions = {expected_decisions, want};
   endtask

   task automatic check_decision(input decision_type got);
      decision_type want;
      if (expected_decisions.size() == 0) begin
         report_mismatch($sformatf("result %h arrived with no request pending", got));
      end else begin
         want = expected_decisions.pop_front();
         compare_field("keep", got.keep, want.keep);
         compare_field("kept_slot", got.slot, want.slot);
         compare_field("box_position", got.position, want.position);
         compare_field("store_full", got.store_full, want.store_full);
      end
   endtask

   always @(posedge clock) begin
      box_type arriving;
      if (reset) begin
         iou_limit = THRESH_RESET;
         kept_total = 0;
         next_position = '0;
         expected_decisions.delete();
      end else begin
         if (csr_wr_en) begin
            iou_limit = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_decision(decision_type'(rsp_tdata));
         end
         if (req_tvalid && req_tready) begin
            arriving.left = req_tdata[15:0];
            arriving.top = req_tdata[31:16];
            arriving.right = req_tdata[47:32];
            arriving.bottom = req_tdata[63:48];
            predict_decision(arriving, req_tuser);
         end
      end
      owed <= expected_decisions.size();
   end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Top of the box suppression testbench: clock, reset, request stimulus and verdict.
`default_nettype none
module tb_top
   import bnms_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [23:0] rsp_tdata;
   int          mismatch_count;
   int          decisions_owed;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_asks = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   always #5 clock = ~clock;

   box_nonmax_suppression #(
      .MAX_KEPT(64)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   box_nms_checker #(
      .MAX_KEPT(64)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .decisions_owed(decisions_owed)
   );

   // The receiver holds off for a long stretch whenever the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_taken != hold_asks) begin
         hold_taken = hold_asks;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int clip16(input int v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   function automatic int jitter(input int amount);
      return int'($urandom_range(2 * amount)) - amount;
   endfunction

   task automatic send_box(input int l, input int t, input int r, input int b,
                           input bit first_box);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {16'(b), 16'(r), 16'(t), 16'(l)};
      req_tuser <= first_box;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decisions_owed != 0);
   endtask

   task automatic set_threshold(input logic [15:0] value);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_sets(input int count);
      int sent;
      int set_len;
      int nearby_pct;
      int pick;
      int jit;
      int cx;
      int cy;
      int boxes [72][4];
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            send_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(1));
            sent++;
         end else begin
            if ($urandom_range(9) == 0) begin
               set_len = $urandom_range(64, 72);
               nearby_pct = 10;
            end else begin
               set_len = $urandom_range(1, 24);
               nearby_pct = 55;
            end
            for (int j = 0; j < set_len; j++) begin
               if (j > 0 && $urandom_range(99) < nearby_pct) begin
                  pick = $urandom_range(j - 1);
                  jit = $urandom_range(1, 400);
                  for (int c = 0; c < 4; c++) begin
                     boxes[j][c] = clip16(boxes[pick][c] + jitter(jit));
                  end
               end else begin
                  cx = int'($urandom_range(60000)) - 30000;
                  cy = int'($urandom_range(60000)) - 30000;
                  boxes[j][0] = cx;
                  boxes[j][1] = cy;
                  boxes[j][2] = clip16(cx + int'($urandom_range(3000)));
                  boxes[j][3] = clip16(cy + int'($urandom_range(3000)));
                  if ($urandom_range(19) == 0) begin
                     boxes[j][2] = cx - int'($urandom_range(1, 500));
                  end
               end
               send_box(boxes[j][0], boxes[j][1], boxes[j][2], boxes[j][3], j == 0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_box(-32768, -32768, 32767, 32767, 1'b1);
      send_box(-32768, -32768, 32767, 32767, 1'b0);
      send_box(100, 100, 50, 300, 1'b0);
      send_box(0, 0, 160, 160, 1'b0);
      send_box(160, 0, 320, 160, 1'b0);
      send_box(0, 0, 160, 160, 1'b0);
      send_box(32767, -32768, 32767, 32767, 1'b0);
      send_box(0, 0, 152, 160, 1'b0);
      send_box(0, 0, 80, 160, 1'b0);
      send_box(0, 0, 64, 160, 1'b0);
      send_box(-32768, 32767, -32768, -32768, 1'b1);
      send_box(-32768, 32767, -32768, -32768, 1'b0);

      set_threshold(16'd32768);
      send_box(0, 0, 160, 160, 1'b1);
      send_box(0, 0, 80, 160, 1'b0);
      send_box(0, 0, 81, 160, 1'b0);

      set_threshold(16'd0);
      send_box(0, 0, 160, 160, 1'b1);
      send_box(159, 159, 400, 400, 1'b0);
      send_box(160, 0, 300, 160, 1'b0);

      set_threshold(16'hFFFF);
      send_box(0, 0, 160, 160, 1'b1);
      send_box(0, 0, 160, 160, 1'b0);
      send_box(0, 0, 160, 159, 1'b0);

      // Seventy disjoint boxes overrun the store of sixty-four entries.
      set_threshold(THRESH_RESET);
      for (int k = 0; k < 70; k++) begin
         send_box((k % 10) * 400 - 2000, (k / 10) * 400 - 2000,
                  (k % 10) * 400 - 1800, (k / 10) * 400 - 1800, k == 0);
      end

      // One long set of duplicates keeps the first box and suppresses the rest.
      for (int k = 0; k < 60; k++) begin
         send_box(0, 0, 1600, 1600, k == 0);
      end

      for (int m = 0; m < 3; m++) begin
         set_threshold(16'($urandom_range(65535)));
         send_idle_pct = (m == 0) ? 33 : (m == 1) ? 80 : 0;
         recv_idle_pct = (m == 0) ? 80 : (m == 1) ? 33 : 0;
         send_random_sets(150);
         set_threshold((m == 0) ? 16'd0 : (m == 1) ? 16'hFFFF : THRESH_RESET);
         hold_asks++;
         send_random_sets(150);
         set_threshold(16'($urandom_range(20000, 45000)));
         send_random_sets(150);
      end

      wait_for_results();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/bnms_pkg.sv
hw/rtl/box_nonmax_suppression.sv
hw/rtl/bnms_checker.sv
verif/box_nms_checker.sv
verif/tb_top.sv
